// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; defining NO_ASSERTIONS leaves them empty.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression holds at every clock edge outside reset.
`define CAM_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CAM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CAM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CAM_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define CAM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define CAM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/cam_pkg.sv =====
// ---------------------------------------------------------------------------
// Contrast about mean luma: shared package
// Widths, weights, codes, payload and control types, and datapath functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cam_pkg;

  // Frame size limit: the pixel count saturates at 2**MAX_PIXELS_LOG2.
  localparam int MAX_PIXELS_LOG2 = 24;

  localparam int CHAN_W    = 8;
  localparam int LUMA_FRAC = 16;
  localparam int LUMA_W    = CHAN_W + LUMA_FRAC;
  localparam int CNT_W     = MAX_PIXELS_LOG2 + 1;
  localparam int SUM_W     = MAX_PIXELS_LOG2 + LUMA_W;
  localparam int QUOT_W    = CHAN_W;
  localparam int NUM_W     = SUM_W - LUMA_FRAC;
  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int GAIN_W    = 16;
  localparam int DIFF_W    = CHAN_W + 1;
  localparam int PROD_W    = GAIN_W + 1 + DIFF_W;

  // Luma weights in Q0.16; they sum to one.
  localparam logic [LUMA_FRAC-1:0] W_RED   = 16'd19595;
  localparam logic [LUMA_FRAC-1:0] W_GREEN = 16'd38470;
  localparam logic [LUMA_FRAC-1:0] W_BLUE  = 16'd7471;

  // Register map.
  localparam int                PADDR_W       = 3;
  localparam int                REG_IDX_W     = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CONTRAST_GAIN = 1'b0;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 16'd256;

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    OP_ACCUM = 1'b0,
    OP_APPLY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_APPLY,
    BK_DIV
  } back_state_t;

  typedef struct packed {
    op_t               op;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } cam_pix_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } cam_res_t;

  typedef struct packed {
    op_t               op;
    logic              last;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [LUMA_W-1:0] luma;
  } cam_entry_t;

  typedef struct packed {
    logic       valid;
    cam_entry_t entry;
  } cam_slot_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  // Exact pixel luma in Q8.16.
  function automatic logic [LUMA_W-1:0] luma_of(input logic [CHAN_W-1:0] r,
                                               input logic [CHAN_W-1:0] g,
                                               input logic [CHAN_W-1:0] b);
    luma_of = LUMA_W'(r) * LUMA_W'(W_RED) + LUMA_W'(g) * LUMA_W'(W_GREEN)
            + LUMA_W'(b) * LUMA_W'(W_BLUE);
  endfunction

  // Signed distance of a channel from the mean.
  function automatic logic signed [DIFF_W-1:0] chan_diff(input logic [CHAN_W-1:0] ch,
                                                       input logic [CHAN_W-1:0] mean);
    chan_diff = $signed({1'b0, ch}) - $signed({1'b0, mean});
  endfunction

  // Mean plus the scaled distance shifted down by eight, clamped to a channel.
  function automatic logic [CHAN_W-1:0] adjust_ch(input logic signed [PROD_W-1:0] prod,
                                                 input logic [CHAN_W-1:0] mean);
    logic signed [PROD_W-9:0] s;
    logic signed [PROD_W-8:0] v;
    s = $signed(prod[PROD_W-1:8]);
    v = $signed({s[PROD_W-9], s}) + $signed({{(PROD_W-8-CHAN_W+1){1'b0}}, mean});
    if (v[PROD_W-8]) begin
      adjust_ch = '0;
    end else if (|v[PROD_W-9:CHAN_W]) begin
      adjust_ch = '1;
    end else begin
      adjust_ch = v[CHAN_W-1:0];
    end
  endfunction

endpackage

// ===== src/cam_queue.sv =====
// ---------------------------------------------------------------------------
// Request queue
// Short first-in first-out store between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cam_queue
  import cam_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cam_slot_t push,
  input  logic      pop,
  output logic      full,
  output cam_slot_t head
);

  cam_entry_t        entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

  // Stored requests.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

endmodule

// ===== src/cam_front.sv =====
// ---------------------------------------------------------------------------
// Front end
// Takes pixel requests, classifies them and works out the luma of each
// accumulate request before it enters the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cam_front
  import cam_pkg::*;
(
  input  logic      pix_valid,
  output logic      pix_ready,
  input  cam_pix_t  pix,
  input  logic      q_full,
  output cam_slot_t push
);

  // A request is taken whenever the queue has room.
  assign pix_ready = !q_full;

  // Luma is only needed by accumulate requests; apply requests carry zero.
  always_comb begin
    push.valid       = pix_valid && !q_full;
    push.entry.op    = pix.op;
    push.entry.last  = pix.last && (pix.op == OP_ACCUM);
    push.entry.red   = pix.red;
    push.entry.green = pix.green;
    push.entry.blue  = pix.blue;
    push.entry.luma  = (pix.op == OP_ACCUM) ? luma_of(pix.red, pix.green, pix.blue) : '0;
  end

endmodule

// ===== src/cam_divider.sv =====
// ---------------------------------------------------------------------------
// Mean divider
// Restoring divider giving one quotient bit a cycle; the quotient of the
// luma sum by the pixel count never exceeds one channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cam_divider
  import cam_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [QUOT_W-1:0] quo;
  logic              den_zero;
  logic [NUM_W:0]    trial;
  logic              ge;

  // Trial subtraction of the shifted divisor.
  assign trial = {1'b0, rem} - {1'b0, dsh};
  assign ge    = !trial[NUM_W];

  // Sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIV_STEPS - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, divisor and quotient.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= req.dividend;
      dsh      <= {req.divisor, {(QUOT_W-1){1'b0}}};
      den_zero <= (req.divisor == '0);
    end else if (busy) begin
      if (ge) begin
        rem <= trial[NUM_W-1:0];
      end
      dsh <= dsh >> 1;
      quo <= {quo[QUOT_W-2:0], ge};
    end
  end

  // An empty frame gives a mean of zero.
  assign rsp.done     = done;
  assign rsp.quotient = den_zero ? '0 : quo;

endmodule

// ===== src/cam_back.sv =====
// ---------------------------------------------------------------------------
// Back end
// Carries out queued requests: sums luma, forms the mean on the last pixel
// and applies the contrast gain into the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cam_back
  import cam_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cam_slot_t         head,
  output logic              pop,
  input  logic [GAIN_W-1:0] gain,
  output logic              res_valid,
  input  logic              res_ready,
  output cam_res_t          res
);

  back_state_t              state;
  back_state_t              state_next;
  logic [SUM_W-1:0]         luma_sum;
  logic [CNT_W-1:0]         pixel_count;
  logic [CHAN_W-1:0]        mean_luma;
  logic signed [PROD_W-1:0] prod_red;
  logic signed [PROD_W-1:0] prod_green;
  logic signed [PROD_W-1:0] prod_blue;
  logic [SUM_W-1:0]         sum_add;
  logic [CNT_W-1:0]         count_add;
  logic                     saturated;
  logic                     out_free;
  logic                     do_accum;
  logic                     load_prod;
  logic                     load_out;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign out_free  = !res_valid || res_ready;
  assign saturated = pixel_count[CNT_W-1];
  assign sum_add   = saturated ? luma_sum : luma_sum + SUM_W'(head.entry.luma);
  assign count_add = saturated ? pixel_count : pixel_count + 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_RUN: begin
        if (head.valid) begin
          if (head.entry.op == OP_APPLY) begin
            state_next = BK_APPLY;
          end else if (head.entry.last) begin
            state_next = BK_DIV;
          end
        end
      end
      BK_APPLY: begin
        if (out_free) begin
          state_next = BK_RUN;
        end
      end
      BK_DIV: begin
        if (div_rsp.done) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // Controls for the current state.
  always_comb begin
    pop              = 1'b0;
    do_accum         = 1'b0;
    load_prod        = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_add[SUM_W-1:LUMA_FRAC];
    div_req.divisor  = count_add;
    unique case (state)
      BK_RUN: begin
        pop = head.valid;
        if (head.valid) begin
          if (head.entry.op == OP_APPLY) begin
            load_prod = 1'b1;
          end else begin
            do_accum      = 1'b1;
            div_req.start = head.entry.last;
          end
        end
      end
      BK_APPLY: load_out = out_free;
      BK_DIV:   ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Frame accumulation and mean.
  always_ff @(posedge clk) begin
    if (rst) begin
      luma_sum    <= '0;
      pixel_count <= '0;
      mean_luma   <= '0;
    end else begin
      if (do_accum) begin
        if (head.entry.last) begin
          luma_sum    <= '0;
          pixel_count <= '0;
        end else begin
          luma_sum    <= sum_add;
          pixel_count <= count_add;
        end
      end
      if (div_rsp.done) begin
        mean_luma <= div_rsp.quotient;
      end
    end
  end

  // Gain products, one lane per channel.
  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod_red   <= $signed({1'b0, gain}) * chan_diff(head.entry.red, mean_luma);
      prod_green <= $signed({1'b0, gain}) * chan_diff(head.entry.green, mean_luma);
      prod_blue  <= $signed({1'b0, gain}) * chan_diff(head.entry.blue, mean_luma);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.out_red   <= adjust_ch(prod_red, mean_luma);
      res.out_green <= adjust_ch(prod_green, mean_luma);
      res.out_blue  <= adjust_ch(prod_blue, mean_luma);
    end
  end

  cam_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // The count only saturates at exactly the frame limit.
  `CAM_ASSERT_IMPLIES(a_count_limit, clk, rst, pixel_count[CNT_W-1], pixel_count[CNT_W-2:0] == '0, "pixel count beyond limit")
  // The divider answers only while the back end waits for it.
  `CAM_ASSERT_IMPLIES(a_done_in_div, clk, rst, div_rsp.done, state == BK_DIV, "divider result outside division")
  // A frame's sum and count are cleared while its mean is formed.
  `CAM_ASSERT_IMPLIES(a_clear_in_div, clk, rst, state == BK_DIV, luma_sum == '0 && pixel_count == '0, "sum not cleared")
  // Starting a division leads into the division state.
  `CAM_ASSERT_NEXT(a_start_div, clk, rst, div_req.start, state == BK_DIV, "division started without waiting")

endmodule

// ===== src/contrast_about_mean_luma_top.sv =====
// ---------------------------------------------------------------------------
// Contrast about mean luma: top level
// Two-pass contrast adjustment of RGB pixels about a frame's mean luma.
// ---------------------------------------------------------------------------
// Usage: pixel requests arrive on pix (valid/ready). An accumulate request
// (op = 0) adds the pixel's luma to the frame sum and gives no result; the
// one marked last forms the frame mean and clears the sum and count. An apply
// request (op = 1) gives one result on res (valid/ready): each channel moved
// about the mean by contrast_gain (Q8.8), clamped to 0..255.
// An apply request passes through the queue, the gain product registers and the
// result register. The back end handles accumulate requests in its run state,
// apply requests in its run and apply states, and a last-marked request also in
// the division state, where a restoring divider forms the mean one quotient bit a
// cycle. A two-entry queue lets the input keep running while the back end is busy.
// Reset clears the sum, the count and the mean (zero) and sets the gain to
// 256. When the receiver stalls, the held result blocks the next apply
// request, the queue fills and pix_ready falls.
// contrast_gain lies at byte address 0 of the APB port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module contrast_about_mean_luma_top
  import cam_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  cam_pix_t           pix,
  output logic               res_valid,
  input  logic               res_ready,
  output cam_res_t           res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [GAIN_W-1:0]    contrast_gain;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 q_full;
  logic                 pop;
  cam_slot_t            push;
  cam_slot_t            head;

  // Register file.
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_gain <= GAIN_RESET;
    end else if (psel && penable && pwrite && reg_idx == REG_CONTRAST_GAIN) begin
      contrast_gain <= pwdata[GAIN_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_CONTRAST_GAIN) ? {{(32-GAIN_W){1'b0}}, contrast_gain} : '0;

  cam_front u_front (
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .q_full    (q_full),
    .push      (push)
  );

  cam_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  cam_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .gain      (contrast_gain),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
